/* hw/rtl/projectile_trajectory_eval_defines.svh */
// ----------------------------------------------------------------------------
// Projectile trajectory evaluator: assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef PROJECTILE_TRAJECTORY_EVAL_DEFINES_SVH
`define PROJECTILE_TRAJECTORY_EVAL_DEFINES_SVH

// same-cycle implication, disabled in reset
`define PTEV_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ptev: implication check failed");

// next-cycle implication, disabled in reset
`define PTEV_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ptev: next-cycle check failed");

// next-cycle implication, active through reset
`define PTEV_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ptev: reset check failed");

`endif

/* hw/rtl/ptev_pkg.sv */
// ----------------------------------------------------------------------------
// ptev_pkg
// Constants, tables and stage payload types of the trajectory evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package ptev_pkg;

  localparam int FRAC_BITS        = 8;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int CW               = 34;
  localparam int ISQ_STEPS        = 18;
  localparam int RIGHT_ANGLE      = 5760;
  localparam int HALF_TURN        = 11520;
  localparam int HAT_SH           = 2 * FRAC_BITS + 1;

  localparam logic [63:0] PI_Q30    = 64'd3373259426;
  localparam logic [63:0] ANG_Q     = PI_Q30 / 64'd11520;
  localparam logic [63:0] ANG_R     = PI_Q30 % 64'd11520;
  localparam logic [63:0] DIV45_MUL = ((64'd1 << 24) + 64'd44) / 64'd45;
  localparam int          DIV45_SH  = 24;

  localparam logic [63:0] GRAV     = ((64'd98 << FRAC_BITS) + 64'd5) / 64'd10;
  localparam int          PEAK_SH  = 44;
  localparam logic [63:0] PEAK_MUL = ((64'd1 << PEAK_SH) + GRAV - 64'd1) / GRAV;
  localparam int          FT_SH    = 38;
  localparam logic [63:0] FT_MUL   = ((64'd1 << FT_SH) + GRAV - 64'd1) / GRAV;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sh026DD3B6A;

  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic [15:0] speed;
    logic [19:0] height;
    logic [19:0] qtime;
    logic        negc;
  } cside_t;

  typedef struct packed {
    logic signed [17:0] vy;
    logic signed [17:0] vx;
    logic [21:0]        peak;
    logic signed [37:0] hat;
    logic signed [31:0] rat;
  } rside_t;

endpackage

`default_nettype wire

/* hw/rtl/ptev_angle.sv */
// ----------------------------------------------------------------------------
// ptev_angle
// Folds the elevation into +-90 degrees and converts it to radians Q30.
// ----------------------------------------------------------------------------
`default_nettype none

module ptev_angle (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire logic               in_valid,
  input  wire logic [15:0]        launch_speed,
  input  wire logic signed [13:0] elevation,
  input  wire logic [19:0]        launch_height,
  input  wire logic [19:0]        query_time,
  output logic                    z_valid,
  output logic signed [ptev_pkg::CW-1:0] z,
  output ptev_pkg::cside_t        side
);

  localparam logic signed [14:0] RA = 15'(ptev_pkg::RIGHT_ANGLE);
  localparam logic signed [14:0] HT = 15'(ptev_pkg::HALF_TURN);

  logic signed [14:0] a_ext, a_f;
  logic               negc_c;
  logic [12:0]        mag_c;

  logic                 v1, v2, v3;
  logic [12:0]          mag1;
  logic                 neg1, neg2, neg3;
  ptev_pkg::cside_t     sd1, sd2, sd3;
  logic [31:0]          pq2, pq3;
  logic [25:0]          pr2;
  logic [36:0]          qd3;
  logic [31:0]          zmag;

  always_comb begin
    a_ext  = 15'(elevation);
    a_f    = a_ext;
    negc_c = 1'b0;
    if (a_ext > RA) begin
      a_f    = HT - a_ext;
      negc_c = 1'b1;
    end else if (a_ext < -RA) begin
      a_f    = -HT - a_ext;
      negc_c = 1'b1;
    end
    mag_c = a_f[14] ? 13'(-a_f) : 13'(a_f);
  end

  assign zmag = pq3 + 32'(qd3[36:ptev_pkg::DIV45_SH]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      z_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      z_valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag1 <= mag_c;
      neg1 <= a_f[14];
      sd1  <= '{speed: launch_speed, height: launch_height, qtime: query_time,
                negc: negc_c};
      pq2  <= 32'(mag1) * 32'(ptev_pkg::ANG_Q[18:0]);
      pr2  <= 26'(mag1) * 26'(ptev_pkg::ANG_R[12:0]) + 26'(ptev_pkg::HALF_TURN / 2);
      neg2 <= neg1;
      sd2  <= sd1;
      qd3  <= 37'(pr2[25:8]) * 37'(ptev_pkg::DIV45_MUL[18:0]);
      pq3  <= pq2;
      neg3 <= neg2;
      sd3  <= sd2;
      z    <= neg3 ? -signed'(34'(zmag)) : signed'(34'(zmag));
      side <= sd3;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ptev_cordic.sv */
// ----------------------------------------------------------------------------
// ptev_cordic
// Rotation-mode CORDIC, one micro-rotation per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptev_cordic #(
  parameter int CORDIC_STEPS = ptev_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        z_valid,
  input  wire logic signed [ptev_pkg::CW-1:0] z_in,
  input  ptev_pkg::cside_t                 side_in,
  output logic                             xy_valid,
  output logic signed [ptev_pkg::CW-1:0]   x_out,
  output logic signed [ptev_pkg::CW-1:0]   y_out,
  output ptev_pkg::cside_t                 side_out
);

  logic signed [ptev_pkg::CW-1:0] x [CORDIC_STEPS+1];
  logic signed [ptev_pkg::CW-1:0] y [CORDIC_STEPS+1];
  logic signed [ptev_pkg::CW-1:0] z [CORDIC_STEPS+1];
  logic                           vld [CORDIC_STEPS+1];
  ptev_pkg::cside_t               sd [CORDIC_STEPS+1];

  assign x[0]   = ptev_pkg::CORDIC_GAIN;
  assign y[0]   = '0;
  assign z[0]   = z_in;
  assign vld[0] = z_valid;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
    logic signed [ptev_pkg::CW-1:0] dx, dy, da;
    assign dx = x[i] >>> i;
    assign dy = y[i] >>> i;
    assign da = signed'(34'(ptev_pkg::ATAN_Q30[i]));

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1] <= sd[i];
        if (!z[i][ptev_pkg::CW-1]) begin
          x[i+1] <= x[i] - dy;
          y[i+1] <= y[i] + dx;
          z[i+1] <= z[i] - da;
        end else begin
          x[i+1] <= x[i] + dy;
          y[i+1] <= y[i] - dx;
          z[i+1] <= z[i] + da;
        end
      end
    end
  end

  assign xy_valid = vld[CORDIC_STEPS];
  assign x_out    = x[CORDIC_STEPS];
  assign y_out    = y[CORDIC_STEPS];
  assign side_out = sd[CORDIC_STEPS];

endmodule

`default_nettype wire

/* hw/rtl/ptev_kin.sv */
// ----------------------------------------------------------------------------
// ptev_kin
// Velocity components, peak height, timed position and the root argument.
// ----------------------------------------------------------------------------
`default_nettype none

module ptev_kin (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        xy_valid,
  input  wire logic signed [ptev_pkg::CW-1:0] x_in,
  input  wire logic signed [ptev_pkg::CW-1:0] y_in,
  input  ptev_pkg::cside_t                 side_in,
  output logic                             k_valid,
  output logic [34:0]                      disc,
  output ptev_pkg::rside_t                 rside
);

  localparam int F = ptev_pkg::FRAC_BITS;
  localparam logic signed [ptev_pkg::CW-1:0] ONE = 34'sh040000000;

  logic signed [ptev_pkg::CW-1:0] sc, cc;
  logic signed [16:0] vs;

  logic v5, v6, v7, v8, v9;
  logic signed [48:0] ps5, pc5;
  logic [19:0] h5, t5, h6, t6, h7, t7, h8, h9;
  logic signed [17:0] vy6, vx6, vy7, vx7, vy8, vx8, vy9, vx9;
  logic [32:0] vysq7, gh7;
  logic signed [38:0] vyt7, vxt7;
  logic [31:0] gt7, pn8;
  logic [34:0] disc8, disc9;
  logic [51:0] gtt8;
  logic signed [31:0] rat8, rat9;
  logic signed [54:0] hp8, hat9;
  logic [64:0] pm9;
  logic signed [35:0] vysq_c;

  always_comb begin
    if (y_in > ONE) sc = ONE;
    else if (y_in < -ONE) sc = -ONE;
    else sc = y_in;
    if (x_in > ONE) cc = ONE;
    else if (x_in[ptev_pkg::CW-1]) cc = '0;
    else cc = x_in;
    if (side_in.negc) cc = -cc;
    vs = signed'({1'b0, side_in.speed});
    vysq_c = 36'(vy6) * 36'(vy6);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
      v6 <= 1'b0;
      v7 <= 1'b0;
      v8 <= 1'b0;
      v9 <= 1'b0;
      k_valid <= 1'b0;
    end else if (en) begin
      v5 <= xy_valid;
      v6 <= v5;
      v7 <= v6;
      v8 <= v7;
      v9 <= v8;
      k_valid <= v9;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ps5 <= 49'(vs) * 49'(sc);
      pc5 <= 49'(vs) * 49'(cc);
      h5  <= side_in.height;
      t5  <= side_in.qtime;

      vy6 <= 18'((ps5 + (49'sd1 <<< 29)) >>> 30);
      vx6 <= 18'((pc5 + (49'sd1 <<< 29)) >>> 30);
      h6  <= h5;
      t6  <= t5;

      vysq7 <= 33'(vysq_c);
      gh7   <= 33'(h6) * 33'(2 * ptev_pkg::GRAV[12:0]);
      vyt7  <= 39'(vy6) * 39'(signed'({1'b0, t6}));
      vxt7  <= 39'(vx6) * 39'(signed'({1'b0, t6}));
      gt7   <= 32'(t6) * 32'(ptev_pkg::GRAV[12:0]);
      vy7 <= vy6;
      vx7 <= vx6;
      h7  <= h6;
      t7  <= t6;

      disc8 <= 35'(vysq7) + 35'(gh7);
      pn8   <= 32'((34'(vysq7) + 34'(ptev_pkg::GRAV[12:0])) >> 1);
      gtt8  <= 52'(gt7) * 52'(t7);
      rat8  <= 32'((vxt7 + (39'sd1 <<< (F - 1))) >>> F);
      hp8   <= (55'(signed'({1'b0, h7})) <<< (2 * F + 1)) + (55'(vyt7) <<< (F + 1));
      vy8 <= vy7;
      vx8 <= vx7;
      h8  <= h7;

      pm9   <= 65'(pn8) * 65'(ptev_pkg::PEAK_MUL[32:0]);
      hat9  <= hp8 - signed'(55'(gtt8));
      disc9 <= disc8;
      rat9  <= rat8;
      vy9 <= vy8;
      vx9 <= vx8;
      h9  <= h8;

      disc <= disc9;
      rside.vy   <= vy9;
      rside.vx   <= vx9;
      rside.rat  <= rat9;
      rside.peak <= 22'(h9) + 22'(pm9[64:ptev_pkg::PEAK_SH]);
      rside.hat  <= 38'((hat9 + (55'sd1 <<< (ptev_pkg::HAT_SH - 1))) >>> ptev_pkg::HAT_SH);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/ptev_isqrt.sv */
// ----------------------------------------------------------------------------
// ptev_isqrt
// Pipelined floor square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module ptev_isqrt (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          k_valid,
  input  wire logic [34:0]   disc,
  input  ptev_pkg::rside_t   side_in,
  output logic               r_valid,
  output logic [ptev_pkg::ISQ_STEPS-1:0] root,
  output ptev_pkg::rside_t   side_out
);

  localparam int N  = ptev_pkg::ISQ_STEPS;
  localparam int NW = 2 * N;
  localparam int RW = N + 4;

  logic [NW-1:0] rad [N+1];
  logic [RW-1:0] rem [N+1];
  logic [N-1:0]  q   [N+1];
  logic          vld [N+1];
  ptev_pkg::rside_t sd [N+1];

  assign rad[0] = NW'(disc);
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign vld[0] = k_valid;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < N; i++) begin : g_bit
    logic [RW-1:0] rt, tt;
    assign rt = {rem[i][RW-3:0], rad[i][NW-1:NW-2]};
    assign tt = RW'({q[i], 2'b01});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (en) begin
        vld[i+1] <= vld[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sd[i+1]  <= sd[i];
        rad[i+1] <= rad[i] << 2;
        if (rt >= tt) begin
          rem[i+1] <= rt - tt;
          q[i+1]   <= {q[i][N-2:0], 1'b1};
        end else begin
          rem[i+1] <= rt;
          q[i+1]   <= {q[i][N-2:0], 1'b0};
        end
      end
    end
  end

  assign r_valid  = vld[N];
  assign root     = q[N];
  assign side_out = sd[N];

endmodule

`default_nettype wire

/* hw/rtl/ptev_post.sv */
// ----------------------------------------------------------------------------
// ptev_post
// Flight time, impact range, clamping and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ptev_post (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          en,
  input  wire logic          r_valid,
  input  wire logic [ptev_pkg::ISQ_STEPS-1:0] root,
  input  ptev_pkg::rside_t   side_in,
  output logic               out_valid,
  output logic [23:0]        peak_height,
  output logic [23:0]        flight_time,
  output logic [27:0]        impact_range,
  output logic [29:0]        range_at_time,
  output logic signed [39:0] height_at_time,
  output logic               saturated
);

  localparam int F = ptev_pkg::FRAC_BITS;

  logic signed [19:0] num_s;
  logic [17:0]        num_c;
  logic [25:0]        nf;

  logic v1, v2;
  logic [52:0] fm1;
  ptev_pkg::rside_t sd1, sd2;
  logic [14:0] ft2;
  logic signed [33:0] rp2;
  logic signed [25:0] rng_c;

  always_comb begin
    num_s = 20'(side_in.vy) + signed'(20'(root));
    num_c = num_s[19] ? '0 : 18'(num_s);
    nf    = (26'(num_c) << F) + 26'(ptev_pkg::GRAV[12:0] >> 1);
    rng_c = 26'((rp2 + (34'sd1 <<< (F - 1))) >>> F);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= r_valid;
      v2 <= v1;
      out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fm1 <= 53'(nf) * 53'(ptev_pkg::FT_MUL[26:0]);
      sd1 <= side_in;

      ft2 <= fm1[52:ptev_pkg::FT_SH];
      rp2 <= 34'(signed'({1'b0, fm1[52:ptev_pkg::FT_SH]})) * 34'(sd1.vx);
      sd2 <= sd1;

      peak_height    <= 24'(sd2.peak);
      flight_time    <= 24'(ft2);
      impact_range   <= rng_c[25] ? '0 : 28'(rng_c);
      range_at_time  <= sd2.rat[31] ? '0 : 30'(sd2.rat);
      height_at_time <= 40'(sd2.hat);
      saturated      <= rng_c[25] | sd2.rat[31];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/projectile_trajectory_eval.sv */
// Throughput: one query per cycle while no stalled result is held; the depth comes from the CORDIC and root pipelines.
// A stalled result freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst, synchronous) clears all valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
// projectile_trajectory_eval
// Launch speed, angle, height and query time in; peak, flight, range, position out.
// ----------------------------------------------------------------------------
`default_nettype none

module projectile_trajectory_eval #(
  parameter int CORDIC_STEPS = ptev_pkg::CORDIC_STEPS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        launch_speed,
  input  wire logic signed [13:0] elevation,
  input  wire logic [19:0]        launch_height,
  input  wire logic [19:0]        query_time,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic [23:0]             peak_height,
  output logic [23:0]             flight_time,
  output logic [27:0]             impact_range,
  output logic [29:0]             range_at_time,
  output logic signed [39:0]      height_at_time,
  output logic                    saturated
);

  logic en;
  logic z_valid, xy_valid, k_valid, r_valid;
  logic signed [ptev_pkg::CW-1:0] z, x, y;
  ptev_pkg::cside_t cs_a, cs_b;
  ptev_pkg::rside_t rs_a, rs_b;
  logic [34:0] disc;
  logic [ptev_pkg::ISQ_STEPS-1:0] root;

  assign en       = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  ptev_angle u_angle (
    .clk, .rst, .en, .in_valid, .launch_speed, .elevation, .launch_height,
    .query_time, .z_valid, .z, .side(cs_a)
  );

  ptev_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk, .rst, .en, .z_valid, .z_in(z), .side_in(cs_a),
    .xy_valid, .x_out(x), .y_out(y), .side_out(cs_b)
  );

  ptev_kin u_kin (
    .clk, .rst, .en, .xy_valid, .x_in(x), .y_in(y), .side_in(cs_b),
    .k_valid, .disc, .rside(rs_a)
  );

  ptev_isqrt u_isqrt (
    .clk, .rst, .en, .k_valid, .disc, .side_in(rs_a),
    .r_valid, .root, .side_out(rs_b)
  );

  ptev_post u_post (
    .clk, .rst, .en, .r_valid, .root, .side_in(rs_b),
    .out_valid, .peak_height, .flight_time, .impact_range, .range_at_time,
    .height_at_time, .saturated
  );

endmodule

`default_nettype wire

/* hw/rtl/ptev_checker.sv */
// ----------------------------------------------------------------------------
// ptev_checker
// Port-level checks of the trajectory evaluator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "projectile_trajectory_eval_defines.svh"

module ptev_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [23:0] flight_time,
  input wire logic [27:0] impact_range
);

  // input side only backs up behind a held result
  `PTEV_ASSERT_IMPL(a_stall_src, in_stall, out_valid)
  `PTEV_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  // zero flight time means zero range
  `PTEV_ASSERT_IMPL(a_zero_ft, out_valid && (flight_time == 24'd0), impact_range == 28'd0)
  `PTEV_ASSERT_RST(a_reset, rst, !out_valid && !in_stall)

endmodule

bind projectile_trajectory_eval ptev_checker u_ptev_checker (.*);

`default_nettype wire
